### design/ple_pkg.sv
// Package for the positional list engine: sizes, request and status codes,
// and the item types passed between the sequencer and the top level. No dependencies.
package ple_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int POS_W      = 7;
	localparam int VAL_W      = 32;
	localparam int REQ_W      = 3;
	localparam int STAT_W     = 2;

	localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ     = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]        req_type;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} ple_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] entry_value;
		logic                    last;
	} ple_result_t;

	typedef struct packed {
		logic        valid;
		ple_result_t data;
	} ple_push_t;

endpackage

### design/ple_ifs.sv
// Valid/ready channel interfaces for request and result items.
// Depends on ple_pkg for field widths.
interface ple_req_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output req_type, output position, output item_value,
		input ready);
	modport sink (input valid, input req_type, input position, input item_value,
		output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last;

	modport source (output valid, output status, output entry_value, output last,
		input ready);
	modport sink (input valid, input status, input entry_value, input last,
		output ready);
endinterface

### design/ple_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/ple_seq.sv
// Sequencer of the positional list engine: checks requests, shifts entries
// one at a time through the list RAM, and emits result items. Uses ple_pkg.
module ple_seq import ple_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ple_req_t                in_req,
	output ple_push_t               push,
	input  logic                    push_ok,
	output logic                    ram_we,
	output logic [IDX_W-1:0]        ram_waddr,
	output logic [VAL_W-1:0]        ram_wdata,
	output logic                    ram_re,
	output logic [IDX_W-1:0]        ram_raddr,
	input  logic [VAL_W-1:0]        ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_MOVE,
		S_RD_ISSUE,
		S_RD_EMIT,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    idx_q;
	logic                ins_q;
	logic [VAL_W-1:0]    val_q;
	logic [STAT_W-1:0]   status_q;

	logic [POS_W-1:0]    pos_eff;
	logic [POS_W-1:0]    cnt_pos;
	logic                is_full;
	logic                is_empty;
	logic [CNT_W-1:0]    ptr_inc;
	logic [CNT_W-1:0]    ptr_dec;
	logic                step_done;
	logic                accept;

	assign pos_eff  = (in_req.position == '0) ? POS_W'(1) : in_req.position;
	assign cnt_pos  = POS_W'(cnt_q);
	assign is_full  = (cnt_q == CNT_W'(LIST_DEPTH));
	assign is_empty = (cnt_q == '0);
	assign ptr_inc  = ptr_q + CNT_W'(1);
	assign ptr_dec  = ptr_q - CNT_W'(1);
	// An insert is done once the pointer reaches the open slot; a delete once
	// the entry after the pointer lies beyond the list.
	assign step_done = ins_q ? (ptr_q == idx_q) : (ptr_inc >= cnt_q);
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[IDX_W-1:0];
		push      = '0;
		unique case (state_q)
			S_STEP: begin
				if (step_done) begin
					if (ins_q) begin
						ram_we    = 1'b1;
						ram_wdata = val_q;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ins_q ? ptr_dec[IDX_W-1:0] : ptr_inc[IDX_W-1:0];
				end
			end
			S_MOVE: begin
				ram_we = 1'b1;
			end
			S_RD_ISSUE: begin
				ram_re = 1'b1;
			end
			S_RD_EMIT: begin
				push.valid            = 1'b1;
				push.data.status      = ST_OK;
				push.data.entry_value = ram_rdata;
				push.data.last        = (ptr_inc == cnt_q);
			end
			S_EMIT: begin
				push.valid       = 1'b1;
				push.data.status = status_q;
				push.data.last   = 1'b1;
			end
			S_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			idx_q    <= '0;
			ins_q    <= 1'b0;
			val_q    <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q    <= in_req.item_value;
						status_q <= ST_OK;
						unique case (in_req.req_type)
							REQ_INS_TAIL, REQ_INS_HEAD: begin
								ins_q <= 1'b1;
								ptr_q <= cnt_q;
								idx_q <= (in_req.req_type == REQ_INS_TAIL) ? cnt_q : '0;
								if (is_full) begin
									status_q <= ST_FULL;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_STEP;
								end
							end
							REQ_INS_POS: begin
								ins_q <= 1'b1;
								ptr_q <= cnt_q;
								idx_q <= CNT_W'(pos_eff);
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else if (cnt_pos < pos_eff) begin
									status_q <= ST_BADPOS;
									state_q  <= S_EMIT;
								end else if (is_full) begin
									status_q <= ST_FULL;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_STEP;
								end
							end
							REQ_DEL_POS: begin
								ins_q <= 1'b0;
								ptr_q <= CNT_W'(pos_eff);
								idx_q <= CNT_W'(pos_eff);
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else if (cnt_pos <= pos_eff) begin
									status_q <= ST_BADPOS;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_STEP;
								end
							end
							REQ_DEL_HEAD: begin
								ins_q <= 1'b0;
								ptr_q <= '0;
								idx_q <= '0;
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_STEP;
								end
							end
							REQ_READ: begin
								ptr_q <= '0;
								if (is_empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_RD_ISSUE;
								end
							end
							default: begin
								// Unused codes are dropped without a result.
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_STEP: begin
					if (step_done) begin
						cnt_q   <= ins_q ? (cnt_q + CNT_W'(1)) : (cnt_q - CNT_W'(1));
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					ptr_q   <= ins_q ? ptr_dec : ptr_inc;
					state_q <= S_STEP;
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (push_ok) begin
						if (ptr_inc == cnt_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_inc;
							state_q <= S_RD_ISSUE;
						end
					end
				end
				S_EMIT: begin
					if (push_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/positional_list_engine.sv
// A status item is built in S_EMIT, after S_STEP and S_MOVE have moved any entries;
// insert/delete move up to LIST_DEPTH-1 entries, and a read-out reads one entry per
// item through S_RD_ISSUE and S_RD_EMIT on the single RAM read port.
// Reset (arst_n low, asynchronous) empties the list; the RAM is not cleared.
// A finished item waits in the output register while the next request is taken.
// Depends on ple_pkg, ple_ifs, ple_ram and ple_seq.
module positional_list_engine import ple_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ple_req_if.sink      req,
	ple_rsp_if.source    rsp
);

	ple_req_t    in_req;
	ple_push_t   push;
	logic        push_ok;
	logic        ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic        ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic        out_valid_q;
	ple_result_t out_data_q;

	assign in_req.req_type   = req.req_type;
	assign in_req.position   = req.position;
	assign in_req.item_value = req.item_value;

	// The sequencer checks each request, moves entries and builds result items.
	ple_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_req    (in_req),
		.push      (push),
		.push_ok   (push_ok),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// The list itself: entry 0 is the head, entries below the count are valid.
	ple_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LIST_DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: a new item may load when the register is empty or its
	// current item is being taken in the same cycle.
	assign push_ok = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ok) begin
			out_data_q <= push.data;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_data_q.status;
	assign rsp.entry_value = out_data_q.entry_value;
	assign rsp.last        = out_data_q.last;

endmodule
